[rtl/core/cpc_pkg.sv]
`default_nettype none

package cpc_pkg;

    // Word width of the coordinates, magnitudes and binary angles.
    localparam int DATA_WIDTH = 16;
    // Number of CORDIC micro-rotations, one pipeline stage each.
    localparam int ITERATIONS = 16;

    // Fraction bits carried in x and y inside the datapath.
    localparam int GUARD = 8;
    // Fraction bits of the gain compensation constant.
    localparam int KFRAC = 20;

    // x and y hold the sign, the input word, growth of the gain and the guard bits.
    localparam int XY_W = DATA_WIDTH + GUARD + 3;
    // The angle accumulator is a 32-bit binary angle, 2^31 = pi.
    localparam int Z_W = 32;
    // Signed width of the gain constant.
    localparam int K_W = KFRAC + 2;
    localparam int PROD_W = XY_W + K_W;
    localparam int RSH = GUARD + KFRAC;
    // Width left after the rounding shift.
    localparam int G_W = PROD_W - RSH;

    localparam int SH_W = $clog2(ITERATIONS);
    localparam int ATAN_ENTRIES = 32;
    localparam int ATAN_IDX_W = $clog2(ATAN_ENTRIES);

    // 0.60725293500888 scaled by 2^KFRAC.
    localparam logic signed [K_W-1:0] KGAIN = K_W'(636751);

    localparam logic [Z_W-1:0] QUARTER_TURN = Z_W'(64'h4000_0000);

    // Top two bits of a binary angle.
    localparam logic [1:0] QUAD_SECOND = 2'b01;
    localparam logic [1:0] QUAD_THIRD = 2'b10;

    localparam logic [Z_W-1:0] ATAN_TAB [0:ATAN_ENTRIES-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef logic [SH_W-1:0] shift_t;

    typedef enum logic {
        OP_TO_POLAR = 1'b0,
        OP_TO_RECT  = 1'b1
    } op_t;

    // Working set of one transaction as it moves down the rotation stages.
    typedef struct packed {
        op_t                    op;
        logic                   zero;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [Z_W-1:0]         z;
    } cordic_t;

    function automatic logic [Z_W-1:0] atan_lookup(input shift_t idx);
        return ATAN_TAB[ATAN_IDX_W'(idx)];
    endfunction

endpackage

`default_nettype wire

[rtl/core/cartesian_polar_converter.sv]
`default_nettype none

// Channel   Handshake               Payload
// ------    ---------------------   -----------------------------------------
// input     in_valid / in_ready     op, in_x, in_y, in_mag, in_angle
// output    out_valid / out_ready   out_mag, out_angle, out_x, out_y
//
// Every input transaction gives exactly one output transaction, after one folding stage,
// ITERATIONS micro-rotation stages, one gain multiply stage and one rounding stage that
// also serves as the output register. A new transaction is accepted every cycle while
// the output side does not stall; the throughput is set by the fully
// unrolled rotation stages. Reset clears all valid bits and nothing else.
// Each stage holds its transaction while the stage after it is full and stalled, so
// bubbles are squeezed out and in_ready only drops once every stage holds a transaction.

module cartesian_polar_converter (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  op,
    input  logic signed [cpc_pkg::DATA_WIDTH-1:0] in_x,
    input  logic signed [cpc_pkg::DATA_WIDTH-1:0] in_y,
    input  logic [cpc_pkg::DATA_WIDTH-2:0]        in_mag,
    input  logic signed [cpc_pkg::DATA_WIDTH-1:0] in_angle,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [cpc_pkg::DATA_WIDTH-1:0]        out_mag,
    output logic signed [cpc_pkg::DATA_WIDTH-1:0] out_angle,
    output logic signed [cpc_pkg::DATA_WIDTH-1:0] out_x,
    output logic signed [cpc_pkg::DATA_WIDTH-1:0] out_y
);
    import cpc_pkg::*;

    // Element k of the chain connects the producer of stage k's input to stage k.
    // Element 0 is the folding stage output, element ITERATIONS feeds the gain stage.
    cordic_t             chain_data  [0:ITERATIONS];
    logic [ITERATIONS:0] chain_valid;
    logic [ITERATIONS:0] chain_ready;

    // The folding stage maps the operand onto the range where the micro-rotations
    // converge and presets the angle accumulator accordingly.
    cpc_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op_t'(op)),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_mag    (in_mag),
        .in_angle  (in_angle),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // One micro-rotation per stage. The shift amount is a constant per stage, so each
    // shifter and each arctangent lookup reduces to wiring.
    for (genvar k = 0; k < ITERATIONS; k++)
    begin : g_rot
        cpc_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (shift_t'(k)),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    // Gain compensation, rounding, saturation and the output register.
    cpc_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[ITERATIONS]),
        .in_ready  (chain_ready[ITERATIONS]),
        .in_data   (chain_data[ITERATIONS]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_mag   (out_mag),
        .out_angle (out_angle),
        .out_x     (out_x),
        .out_y     (out_y)
    );

    // The input side only stalls when every stage is occupied and the output is blocked.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> ((&chain_valid) && out_valid && !out_ready))
        else $error("input stalled while the pipeline still has a free stage");

    // A rectangular result never carries polar fields.
    a_rect_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_x != '0 || out_y != '0)) |-> (out_mag == '0 && out_angle == '0))
        else $error("rectangular result with nonzero magnitude or angle");

    // A polar result never carries rectangular fields.
    a_polar_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_mag != '0 || out_angle != '0)) |-> (out_x == '0 && out_y == '0))
        else $error("polar result with nonzero x or y");

endmodule

`default_nettype wire

[rtl/core/cpc_pre.sv]
`default_nettype none

module cpc_pre (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  cpc_pkg::op_t                          op,
    input  logic signed [cpc_pkg::DATA_WIDTH-1:0] in_x,
    input  logic signed [cpc_pkg::DATA_WIDTH-1:0] in_y,
    input  logic [cpc_pkg::DATA_WIDTH-2:0]        in_mag,
    input  logic signed [cpc_pkg::DATA_WIDTH-1:0] in_angle,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output cpc_pkg::cordic_t                      out_data
);
    import cpc_pkg::*;

    logic                         valid_reg;
    cordic_t                      data_reg;
    cordic_t                      data_next;
    logic signed [DATA_WIDTH:0]   xe;
    logic signed [DATA_WIDTH:0]   ye;
    logic signed [DATA_WIDTH:0]   me;
    logic signed [DATA_WIDTH:0]   sx;
    logic signed [DATA_WIDTH:0]   sy;
    logic [Z_W-1:0]               ang_z;
    logic [Z_W-1:0]               z0;

    assign xe = (DATA_WIDTH+1)'(in_x);
    assign ye = (DATA_WIDTH+1)'(in_y);
    assign me = signed'((DATA_WIDTH+1)'(in_mag));
    assign ang_z = Z_W'(unsigned'(in_angle)) << (Z_W - DATA_WIDTH);

    // Fold the input onto the right half plane (vectoring) or onto the
    // quarter turn around the x axis (rotation).
    always_comb
    begin
        sx = xe;
        sy = ye;
        z0 = '0;
        if (op == OP_TO_POLAR)
        begin
            if (xe < 0)
            begin
                if (ye >= 0)
                begin
                    sx = ye;
                    sy = -xe;
                    z0 = QUARTER_TURN;
                end
                else
                begin
                    sx = -ye;
                    sy = xe;
                    z0 = -QUARTER_TURN;
                end
            end
        end
        else
        begin
            case (ang_z[Z_W-1:Z_W-2])
                QUAD_SECOND:
                begin
                    sx = '0;
                    sy = me;
                    z0 = ang_z - QUARTER_TURN;
                end
                QUAD_THIRD:
                begin
                    sx = '0;
                    sy = -me;
                    z0 = ang_z + QUARTER_TURN;
                end
                default:
                begin
                    sx = me;
                    sy = '0;
                    z0 = ang_z;
                end
            endcase
        end
    end

    always_comb
    begin
        data_next.op = op;
        data_next.zero = (op == OP_TO_POLAR) && (in_x == '0) && (in_y == '0);
        data_next.x = XY_W'(sx) <<< GUARD;
        data_next.y = XY_W'(sy) <<< GUARD;
        data_next.z = z0;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

`default_nettype wire

[rtl/core/cpc_stage.sv]
`default_nettype none

module cpc_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cpc_pkg::shift_t       shift,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  cpc_pkg::cordic_t      in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cpc_pkg::cordic_t      out_data
);
    import cpc_pkg::*;

    logic                   valid_reg;
    cordic_t                data_reg;
    cordic_t                data_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic [Z_W-1:0]         step_angle;
    logic                   ccw;

    assign dx = in_data.x >>> shift;
    assign dy = in_data.y >>> shift;
    assign step_angle = atan_lookup(shift);

    // Rotation mode drives the residual angle to zero, vectoring mode drives y to zero.
    assign ccw = (in_data.op == OP_TO_RECT) ? !in_data.z[Z_W-1] : in_data.y[XY_W-1];

    always_comb
    begin
        data_next = in_data;
        if (ccw)
        begin
            data_next.x = in_data.x - dy;
            data_next.y = in_data.y + dx;
            data_next.z = in_data.z - step_angle;
        end
        else
        begin
            data_next.x = in_data.x + dy;
            data_next.y = in_data.y - dx;
            data_next.z = in_data.z + step_angle;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

`default_nettype wire

[rtl/core/cpc_post.sv]
`default_nettype none

module cpc_post (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  cpc_pkg::cordic_t                      in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [cpc_pkg::DATA_WIDTH-1:0]        out_mag,
    output logic signed [cpc_pkg::DATA_WIDTH-1:0] out_angle,
    output logic signed [cpc_pkg::DATA_WIDTH-1:0] out_x,
    output logic signed [cpc_pkg::DATA_WIDTH-1:0] out_y
);
    import cpc_pkg::*;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (RSH - 1));
    localparam logic [Z_W-1:0] ANGLE_HALF = Z_W'(64'd1 << (Z_W - DATA_WIDTH - 1));
    localparam logic signed [G_W-1:0] SAT_HI = G_W'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
    localparam logic signed [G_W-1:0] SAT_LO = -SAT_HI - G_W'(1);
    localparam logic signed [G_W-1:0] MAG_MAX = G_W'((64'd1 << DATA_WIDTH) - 64'd1);

    function automatic logic signed [DATA_WIDTH-1:0] sat_word(input logic signed [G_W-1:0] v);
        logic signed [G_W-1:0] c;
        c = v;
        if (v > SAT_HI)
        begin
            c = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            c = SAT_LO;
        end
        return c[DATA_WIDTH-1:0];
    endfunction

    // Gain multiply stage.
    logic                     mul_valid_reg;
    logic                     mul_ready;
    op_t                      mul_op_reg;
    logic                     mul_zero_reg;
    logic [Z_W-1:0]           mul_z_reg;
    logic signed [PROD_W-1:0] mul_px_reg;
    logic signed [PROD_W-1:0] mul_py_reg;

    // Rounding and saturation stage, which is also the output register.
    logic                         res_valid_reg;
    logic [DATA_WIDTH-1:0]        res_mag_reg;
    logic signed [DATA_WIDTH-1:0] res_angle_reg;
    logic signed [DATA_WIDTH-1:0] res_x_reg;
    logic signed [DATA_WIDTH-1:0] res_y_reg;
    logic [DATA_WIDTH-1:0]        res_mag_next;
    logic signed [DATA_WIDTH-1:0] res_angle_next;
    logic signed [DATA_WIDTH-1:0] res_x_next;
    logic signed [DATA_WIDTH-1:0] res_y_next;

    logic signed [PROD_W-1:0] sum_x;
    logic signed [PROD_W-1:0] sum_y;
    logic signed [G_W-1:0]    gx;
    logic signed [G_W-1:0]    gy;
    logic [Z_W-1:0]           ang_sum;

    assign mul_ready = !res_valid_reg || out_ready;
    assign in_ready = !mul_valid_reg || mul_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                mul_valid_reg <= in_valid;
            end
            if (mul_ready)
            begin
                res_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mul_op_reg <= in_data.op;
            mul_zero_reg <= in_data.zero;
            mul_z_reg <= in_data.z;
            mul_px_reg <= PROD_W'(in_data.x) * PROD_W'(KGAIN);
            mul_py_reg <= PROD_W'(in_data.y) * PROD_W'(KGAIN);
        end
    end

    assign sum_x = mul_px_reg + ROUND_HALF;
    assign sum_y = mul_py_reg + ROUND_HALF;
    assign gx = sum_x[PROD_W-1:RSH];
    assign gy = sum_y[PROD_W-1:RSH];
    assign ang_sum = mul_z_reg + ANGLE_HALF;

    always_comb
    begin
        res_mag_next = '0;
        res_angle_next = '0;
        res_x_next = '0;
        res_y_next = '0;
        if (mul_op_reg == OP_TO_RECT)
        begin
            res_x_next = sat_word(gx);
            res_y_next = sat_word(gy);
        end
        else if (!mul_zero_reg)
        begin
            // x stays non-negative in vectoring mode.
            res_mag_next = (gx > MAG_MAX) ? MAG_MAX[DATA_WIDTH-1:0] : gx[DATA_WIDTH-1:0];
            res_angle_next = ang_sum[Z_W-1:Z_W-DATA_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_valid_reg && mul_ready)
        begin
            res_mag_reg <= res_mag_next;
            res_angle_reg <= res_angle_next;
            res_x_reg <= res_x_next;
            res_y_reg <= res_y_next;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_mag = res_mag_reg;
    assign out_angle = res_angle_reg;
    assign out_x = res_x_reg;
    assign out_y = res_y_reg;

endmodule

`default_nettype wire
